@@ sv/bship_pkg.sv @@
// Shared types and constants for the Burning Ship escape-time block.
// No dependencies; imported by the controller, the datapath, the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bship_pkg;

    // Fixed-point format: signed Q4.28
    localparam int FRAC_BITS = 28;
    localparam logic [35:0] ESCAPE_LIMIT = 36'(64'd4 << FRAC_BITS);

    // Configuration register indexes
    localparam logic [2:0] REG_MAX_ITER = 3'd0;
    localparam logic [2:0] REG_MIN_RE   = 3'd1;
    localparam logic [2:0] REG_MIN_IM   = 3'd2;
    localparam logic [2:0] REG_STEP_RE  = 3'd3;
    localparam logic [2:0] REG_STEP_IM  = 3'd4;

    // Register values after reset
    localparam logic [9:0]         MAX_ITER_RST = 10'd155;
    localparam logic signed [31:0] MIN_RE_RST   = -32'sd590558003;
    localparam logic signed [31:0] MIN_IM_RST   = -32'sd590558003;
    localparam logic [30:0]        STEP_RE_RST  = 31'd969933;
    localparam logic [30:0]        STEP_IM_RST  = 31'd891290;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_MUL,
        ST_UPD,
        ST_FIN
    } bship_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture pixel and form coordinate products
        logic coord;  // saturate c, clear z and the count
        logic mul;    // register the three products
        logic upd;    // write the next z and advance the count
        logic emit;   // write the output register
    } bship_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic limit;   // count has reached max_iter
        logic escape;  // re^2 + im^2 reached 4.0
    } bship_status_t;

    // Clamp a 44-bit signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        logic signed [31:0] r;
        if (!v[43] && (|v[42:31])) begin
            r = 32'sh7FFF_FFFF;
        end else if (v[43] && !(&v[42:31])) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/burning_ship_escape_time.sv @@
// Burning Ship escape-time evaluator, one pixel at a time.
// After an input transfer the block forms the coordinate, then runs multiply/update
// state pairs until the point escapes or the count reaches max_iter, then writes the result.
// The next pixel transfer can come in the cycle after the result is written, not while a pixel
// is still in flight; a stalled result holds the next one in the final state.
// Reset (rst_n low, asynchronous) empties the block and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module burning_ship_escape_time
    import bship_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [9:0]  column,
    input  wire logic [9:0]  row,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [9:0]       iterations,
    output logic [9:0]       out_column,
    output logic [9:0]       out_row
);

    bship_cmd_t    cmd;
    bship_status_t status;
    bship_state_t  state;

    // Sequence the work
    bship_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .state     (state)
    );

    // Do the arithmetic
    bship_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .column     (column),
        .row        (row),
        .cmd        (cmd),
        .status     (status),
        .iterations (iterations),
        .out_column (out_column),
        .out_row    (out_row)
    );

`ifndef SYNTHESIS
    // Never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || !out_stall))
        else $error("result written over a pending result");

    // After an input transfer the block is busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after input transfer");

    // At most one datapath command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

    // A result leaves only from the final state
    a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (state == ST_FIN))
        else $error("result written outside the final state");
`endif

endmodule

`default_nettype wire

@@ sv/bship_ctrl.sv @@
// Controller state machine for the Burning Ship escape-time block.
// Depends on bship_pkg; drives the datapath through bship_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module bship_ctrl
    import bship_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire bship_status_t status,
    output bship_cmd_t         cmd,
    output bship_state_t       state
);

    bship_state_t state_reg;
    bship_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_free;

    // Hold the state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Sequence one pixel: coordinates, multiply/update pairs, result
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_COORD;
                end
            end
            ST_COORD:
            begin
                cmd.coord  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (status.limit)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (status.escape)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.upd    = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Keep the result valid until its transfer completes
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign state     = state_reg;

endmodule

`default_nettype wire

@@ sv/bship_dp.sv @@
// Datapath for the Burning Ship escape-time block: configuration registers,
// coordinate mapping, the iterate registers and the output register. Depends on bship_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bship_dp
    import bship_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic [9:0] column,
    input  wire logic [9:0] row,
    input  wire bship_cmd_t cmd,
    output bship_status_t   status,
    output logic [9:0]      iterations,
    output logic [9:0]      out_column,
    output logic [9:0]      out_row
);

    // Configuration
    logic [9:0]         max_iter_reg;
    logic signed [31:0] min_re_reg;
    logic signed [31:0] min_im_reg;
    logic [30:0]        step_re_reg;
    logic [30:0]        step_im_reg;

    // Pixel and coordinate
    logic [9:0]         col_reg;
    logic [9:0]         row_reg;
    logic [40:0]        off_re_reg;
    logic [40:0]        off_im_reg;
    logic signed [31:0] c_re_reg;
    logic signed [31:0] c_im_reg;

    // Iterate
    logic signed [31:0] re_reg;
    logic signed [31:0] im_reg;
    logic [9:0]         count_reg;
    logic [62:0]        sqr_reg;
    logic [62:0]        sqi_reg;
    logic [62:0]        crs_reg;

    // Output register
    logic [9:0]         iter_out_reg;
    logic [9:0]         col_out_reg;
    logic [9:0]         row_out_reg;

    logic [31:0]        are;
    logic [31:0]        aim;
    logic [63:0]        prod_rr;
    logic [63:0]        prod_ii;
    logic [63:0]        prod_ri;
    logic [34:0]        sq_re;
    logic [34:0]        sq_im;
    logic [35:0]        cross2;
    logic [35:0]        mag_sum;
    logic signed [43:0] nre;
    logic signed [43:0] nim;
    logic signed [43:0] cre_full;
    logic signed [43:0] cim_full;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RST;
            min_re_reg   <= MIN_RE_RST;
            min_im_reg   <= MIN_IM_RST;
            step_re_reg  <= STEP_RE_RST;
            step_im_reg  <= STEP_IM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_ITER: max_iter_reg <= cfg_data[9:0];
                REG_MIN_RE:   min_re_reg   <= cfg_data;
                REG_MIN_IM:   min_im_reg   <= cfg_data;
                REG_STEP_RE:  step_re_reg  <= cfg_data[30:0];
                REG_STEP_IM:  step_im_reg  <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // Coordinate sums, exact before clamping
    assign cre_full = {{12{min_re_reg[31]}}, min_re_reg} + $signed({3'b000, off_re_reg});
    assign cim_full = {{12{min_im_reg[31]}}, min_im_reg} + $signed({3'b000, off_im_reg});

    // Magnitudes of the current iterate and their products
    assign are     = re_reg[31] ? (~re_reg + 32'd1) : re_reg;
    assign aim     = im_reg[31] ? (~im_reg + 32'd1) : im_reg;
    assign prod_rr = {32'd0, are} * {32'd0, are};
    assign prod_ii = {32'd0, aim} * {32'd0, aim};
    assign prod_ri = {32'd0, are} * {32'd0, aim};

    // Scale products back to Q4.28, test escape and form the next iterate
    assign sq_re   = sqr_reg[62:28];
    assign sq_im   = sqi_reg[62:28];
    assign cross2  = crs_reg[62:27];
    assign mag_sum = {1'b0, sq_re} + {1'b0, sq_im};
    assign nre     = $signed({9'd0, sq_re}) - $signed({9'd0, sq_im})
                     + {{12{c_re_reg[31]}}, c_re_reg};
    assign nim     = $signed({8'd0, cross2}) + {{12{c_im_reg[31]}}, c_im_reg};

    assign status.escape = (mag_sum >= ESCAPE_LIMIT);
    assign status.limit  = (count_reg >= max_iter_reg);

    // Pixel capture, coordinate mapping and iteration registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg    <= column;
            row_reg    <= row;
            off_re_reg <= {31'd0, column} * {10'd0, step_re_reg};
            off_im_reg <= {31'd0, row} * {10'd0, step_im_reg};
        end
        if (cmd.coord)
        begin
            c_re_reg  <= sat32(cre_full);
            c_im_reg  <= sat32(cim_full);
            re_reg    <= '0;
            im_reg    <= '0;
            count_reg <= '0;
        end
        if (cmd.mul)
        begin
            sqr_reg <= prod_rr[62:0];
            sqi_reg <= prod_ii[62:0];
            crs_reg <= prod_ri[62:0];
        end
        if (cmd.upd)
        begin
            re_reg    <= sat32(nre);
            im_reg    <= sat32(nim);
            count_reg <= count_reg + 10'd1;
        end
        if (cmd.emit)
        begin
            iter_out_reg <= count_reg;
            col_out_reg  <= col_reg;
            row_out_reg  <= row_reg;
        end
    end

    assign iterations = iter_out_reg;
    assign out_column = col_out_reg;
    assign out_row    = row_out_reg;

endmodule

`default_nettype wire

@@ verif/escape_time_checker.sv @@
// Checker for the Burning Ship escape-time block: predicts each pixel's result and compares.
// Depends on bship_pkg for register indexes, reset values and the fixed-point format.
`timescale 1ns / 1ps

module escape_time_checker
    import bship_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [9:0]  column,
    input  logic [9:0]  row,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [9:0]  iterations,
    input  logic [9:0]  out_column,
    input  logic [9:0]  out_row,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [9:0] iterations;
        logic [9:0] column;
        logic [9:0] row;
    } pixel_result_t;

    // Local copy of the configuration registers
    logic [9:0]         limit_iter;
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        step_re;
    logic [30:0]        step_im;

    pixel_result_t expected_pixels[$];
    int            errors;

    // Clamp to the signed 32-bit range
    function automatic longint clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return longint'(32'sh7FFF_FFFF);
        if (v < longint'(32'sh8000_0000))
            return longint'(32'sh8000_0000);
        return v;
    endfunction

    // Iterate the map for one pixel and return how many steps ran before escape or the limit
    function automatic logic [9:0] escape_count(input logic [9:0] col, input logic [9:0] row_idx);
        longint      c_re;
        longint      c_im;
        longint      z_re;
        longint      z_im;
        logic [63:0] mag_re;
        logic [63:0] mag_im;
        logic [63:0] sq_re;
        logic [63:0] sq_im;
        logic [63:0] cross2;
        int          n;
        c_re = clamp32(longint'(origin_re) + longint'(col) * longint'(step_re));
        c_im = clamp32(longint'(origin_im) + longint'(row_idx) * longint'(step_im));
        z_re = 0;
        z_im = 0;
        n    = 0;
        while (n < int'(limit_iter))
        begin
            mag_re = (z_re < 0) ? 64'(-z_re) : 64'(z_re);
            mag_im = (z_im < 0) ? 64'(-z_im) : 64'(z_im);
            sq_re  = (mag_re * mag_re) >> FRAC_BITS;
            sq_im  = (mag_im * mag_im) >> FRAC_BITS;
            cross2 = (mag_re * mag_im) >> (FRAC_BITS - 1);
            if (sq_re + sq_im >= (64'd4 << FRAC_BITS))
                break;
            z_re = clamp32(longint'(sq_re) - longint'(sq_im) + c_re);
            z_im = clamp32(longint'(cross2) + c_im);
            n++;
        end
        return 10'(n);
    endfunction

    // Track register writes, predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t seen;
        pixel_result_t want;
        if (!rst_n)
        begin
            limit_iter = MAX_ITER_RST;
            origin_re  = MIN_RE_RST;
            origin_im  = MIN_IM_RST;
            step_re    = STEP_RE_RST;
            step_im    = STEP_IM_RST;
            expected_pixels.delete();
            errors     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Register writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_ITER: limit_iter = cfg_data[9:0];
                    REG_MIN_RE:   origin_re  = cfg_data;
                    REG_MIN_IM:   origin_im  = cfg_data;
                    REG_STEP_RE:  step_re    = cfg_data[30:0];
                    REG_STEP_IM:  step_im    = cfg_data[30:0];
                    default:      ;
                endcase
            end

            // Compare a result transfer with the oldest prediction
            if (out_valid && !out_stall)
            begin
                seen.iterations = iterations;
                seen.column     = out_column;
                seen.row        = out_row;
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: unexpected result: iterations %0d column %0d row %0d",
                                 $realtime, iterations, out_column, out_row);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%t: mismatch: expected iterations %0d column %0d row %0d,",
                                      " got iterations %0d column %0d row %0d"},
                                     $realtime, want.iterations, want.column, want.row,
                                     iterations, out_column, out_row);
                    end
                end
            end

            // Predict a pixel transfer
            if (in_valid && !in_stall)
            begin
                want.iterations = escape_count(column, row);
                want.column     = column;
                want.row        = row;
                expected_pixels.push_back(want);
            end

            pending    <= expected_pixels.size();
            fail_count <= errors;
        end
    end

endmodule

@@ verif/tb_burning_ship_escape_time.sv @@
// Testbench top for burning_ship_escape_time: clock, reset, register set-up and pixel stimulus.
// Depends on bship_pkg, the block itself and escape_time_checker, which does the comparing.
`timescale 1ns / 1ps

module tb_burning_ship_escape_time;
    import bship_pkg::*;

    typedef enum logic [2:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH,
        IDLE_HOLD
    } idle_mode_t;

    localparam int HOLD_LEN   = 400;
    localparam int PHASE_PIX  = 190;
    localparam int NUM_PHASES = 8;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [2:0]  cfg_index  = REG_MAX_ITER;
    logic [31:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [9:0]  column     = '0;
    logic [9:0]  row        = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [9:0]  iterations;
    logic [9:0]  out_column;
    logic [9:0]  out_row;

    int          fail_count;
    int          pending;
    idle_mode_t  idle_mode  = IDLE_NONE;
    int          hold_cycles;
    logic        hold_done;

    always #5 clk = ~clk;

    burning_ship_escape_time DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .column     (column),
        .row        (row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .iterations (iterations),
        .out_column (out_column),
        .out_row    (out_row)
    );

    escape_time_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .column     (column),
        .row        (row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .iterations (iterations),
        .out_column (out_column),
        .out_row    (out_row),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Percentage of cycles a side sits out in the given mode
    function automatic int idle_percent(input idle_mode_t mode, input logic sender);
        case (mode)
            IDLE_SEND: return sender ? 62 : 0;
            IDLE_RECV: return sender ? 0 : 62;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    // Receiver: one long hold-off in hold mode, random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end
        else if (idle_mode == IDLE_HOLD && !hold_done)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_LEN - 1)
                hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < idle_percent(idle_mode, 1'b0));
        end
    end

    // Offer one pixel, with random gaps first, and hold it until the transfer
    task automatic offer_pixel(input logic [9:0] col, input logic [9:0] row_idx);
        while ($urandom_range(99) < idle_percent(idle_mode, 1'b1))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        column   <= col;
        row      <= row_idx;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait until every predicted result has been transferred
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all five registers, then a write to an unused index that must be ignored
    task automatic load_settings(input logic [9:0] limit, input logic [31:0] org_re,
                                 input logic [31:0] org_im, input logic [30:0] inc_re,
                                 input logic [30:0] inc_im);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_ITER;
        cfg_data  <= {22'($urandom), limit};
        @(posedge clk);
        cfg_index <= REG_MIN_RE;
        cfg_data  <= org_re;
        @(posedge clk);
        cfg_index <= REG_MIN_IM;
        cfg_data  <= org_im;
        @(posedge clk);
        cfg_index <= REG_STEP_RE;
        cfg_data  <= {1'($urandom), inc_re};
        @(posedge clk);
        cfg_index <= REG_STEP_IM;
        cfg_data  <= {1'($urandom), inc_im};
        @(posedge clk);
        cfg_index <= 3'(REG_STEP_IM + 3'd1 + 3'($urandom_range(2)));
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Pick a random setting: mostly a jittered view of the ship, sometimes anything
    task automatic random_settings();
        logic [9:0]  limit;
        logic [31:0] org_re;
        logic [31:0] org_im;
        logic [30:0] inc_re;
        logic [30:0] inc_im;
        if ($urandom_range(7) == 0)
            limit = 10'($urandom_range(3));
        else
            limit = 10'($urandom_range(120, 4));
        if ($urandom_range(3) != 0)
        begin
            org_re = 32'(int'(MIN_RE_RST) + int'($urandom_range(1 << 27)) - (1 << 26));
            org_im = 32'(int'(MIN_IM_RST) + int'($urandom_range(1 << 27)) - (1 << 26));
            inc_re = 31'($urandom_range(1500000, 400000));
            inc_im = 31'($urandom_range(1500000, 400000));
        end
        else
        begin
            org_re = $urandom;
            org_im = $urandom;
            inc_re = 31'($urandom);
            inc_im = 31'($urandom);
        end
        load_settings(limit, org_re, org_im, inc_re, inc_im);
    endtask

    // Run limit
    initial
    begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        idle_mode_t phase_mode;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners of the default window and points that never leave the set
        offer_pixel(10'd0, 10'd0);
        offer_pixel(10'd1023, 10'd1023);
        offer_pixel(10'd0, 10'd1023);
        offer_pixel(10'd1023, 10'd0);
        offer_pixel(10'd609, 10'd663);
        offer_pixel(10'd600, 10'd650);
        offer_pixel(10'd512, 10'd512);
        settle();

        // Zero limit: no iteration at all
        load_settings(10'd0, MIN_RE_RST, MIN_IM_RST, STEP_RE_RST, STEP_IM_RST);
        offer_pixel(10'd609, 10'd663);
        offer_pixel(10'd1, 10'd1);
        settle();

        // Coordinates clamp at the top of the range
        load_settings(10'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        offer_pixel(10'd1023, 10'd1023);
        offer_pixel(10'd0, 10'd0);
        offer_pixel(10'd1, 10'd0);
        settle();

        // Most negative origin, zero step
        load_settings(10'd3, 32'h8000_0000, 32'h8000_0000, 31'd0, 31'd0);
        offer_pixel(10'd1023, 10'd1023);
        offer_pixel(10'd0, 10'd0);
        settle();

        // Most negative origin, largest step: clamps high far out
        load_settings(10'd2, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        offer_pixel(10'd1023, 10'd0);
        offer_pixel(10'd0, 10'd1023);
        settle();

        // Largest limit at the origin, which never escapes
        load_settings(10'd1023, 32'd0, 32'd0, 31'd0, 31'd0);
        offer_pixel(10'd5, 10'd5);
        offer_pixel(10'd1023, 10'd1023);
        settle();

        // Random phases, one idling pattern each; the first backs the block up
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            random_settings();
            case (p % 4)
                0:       phase_mode = (p == 0) ? IDLE_HOLD : IDLE_NONE;
                1:       phase_mode = IDLE_SEND;
                2:       phase_mode = IDLE_RECV;
                default: phase_mode = IDLE_BOTH;
            endcase
            idle_mode <= phase_mode;
            @(posedge clk);
            for (int i = 0; i < PHASE_PIX; i++)
                offer_pixel(10'($urandom), 10'($urandom));
            settle();
        end

        idle_mode <= IDLE_NONE;
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/bship_pkg.sv
sv/bship_ctrl.sv
sv/bship_dp.sv
sv/burning_ship_escape_time.sv
verif/escape_time_checker.sv
verif/tb_burning_ship_escape_time.sv
